/* sv/kos_pkg.sv */
package kos_pkg;

  localparam int ANG_W        = 27;  // signed Q9.16 angle with headroom
  localparam int EST_W        = 26;  // eccentric anomaly, signed Q9.16
  localparam int VEC_W        = 36;  // CORDIC vector, signed Q30 with growth
  localparam int MUL_W        = 34;  // multiplier operand, signed
  localparam int PROD_W       = 2 * MUL_W;
  localparam int DIVD_W       = 66;  // dividend / quotient width
  localparam int DVSR_W       = 34;  // divisor width
  localparam int SQ_W         = 61;  // square-root radicand width
  localparam int SQ_STEPS     = (SQ_W + 1) / 2;
  localparam int CORDIC_STEPS = 19;
  localparam int STEP_W       = 5;
  localparam int CNT_W        = 7;

  typedef logic signed [ANG_W-1:0]  ang_t;
  typedef logic signed [EST_W-1:0]  est_t;
  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [MUL_W-1:0]  mop_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam ang_t DEG360 = 27'sd23592960;
  localparam ang_t DEG180 = 27'sd11796480;
  localparam ang_t DEG90  = 27'sd5898240;
  localparam est_t E_LOW  = -26'sd3754937;
  localparam est_t E_HIGH = 26'sd27347897;
  localparam mop_t ONE_Q30     = 34'sd1073741824;
  localparam mop_t RAD_TO_DEG  = 34'sd961263669;
  localparam vec_t CORDIC_GAIN = 36'sd652032874;
  localparam logic [32:0] RADIUS_MAX = 33'h1_FFFF_FFFF;

  localparam logic [3:0]  ITER_RESET = 4'd10;
  localparam logic [15:0] TOL_RESET  = 16'd328;

  localparam logic CFG_ITER_LIMIT = 1'b0;
  localparam logic CFG_TOLERANCE  = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CS_START, ST_CS_WAIT, ST_SC, ST_SC_W,
    ST_EC, ST_EC_W, ST_EC2, ST_EC2_W,
    ST_T2, ST_T2_W, ST_EST,
    ST_F2, ST_DIV_W, ST_CHK,
    ST_SQ, ST_SQ_W, ST_Y2, ST_AT_W,
    ST_RD2, ST_RD2_W, ST_RD3, ST_RD_DIV, ST_DONE
  } state_t;

  typedef enum logic [1:0] {PH_INIT, PH_NEWTON, PH_TRUE, PH_RAD} phase_t;

  typedef struct packed {
    logic start;
    logic vec_mode;   // 1: vectoring (atan2), 0: rotation (sin/cos)
    vec_t x;
    vec_t y;
    ang_t z;
  } cordic_req_t;

  function automatic ang_t atan_deg(input logic [STEP_W-1:0] i);
    ang_t r;
    unique case (i)
      5'd0:  r = 27'sd2949120;
      5'd1:  r = 27'sd1740967;
      5'd2:  r = 27'sd919879;
      5'd3:  r = 27'sd466945;
      5'd4:  r = 27'sd234379;
      5'd5:  r = 27'sd117304;
      5'd6:  r = 27'sd58666;
      5'd7:  r = 27'sd29335;
      5'd8:  r = 27'sd14668;
      5'd9:  r = 27'sd7334;
      5'd10: r = 27'sd3667;
      5'd11: r = 27'sd1833;
      5'd12: r = 27'sd917;
      5'd13: r = 27'sd458;
      5'd14: r = 27'sd229;
      5'd15: r = 27'sd115;
      5'd16: r = 27'sd57;
      5'd17: r = 27'sd29;
      5'd18: r = 27'sd14;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round to nearest, ties up
  function automatic prod_t rnd_sh(input prod_t p, input int unsigned s);
    return (p + (prod_t'(1) <<< (s - 1))) >>> s;
  endfunction

endpackage

/* sv/kos_cordic.sv */
module kos_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  kos_pkg::cordic_req_t req,
  output logic                done,
  output kos_pkg::vec_t       x_out,
  output kos_pkg::vec_t       y_out,
  output kos_pkg::ang_t       z_out
);

  kos_pkg::vec_t x_r, y_r, x_nxt, y_nxt;
  kos_pkg::ang_t z_r, z_nxt;
  logic vec_r;
  logic busy_r, done_r;
  logic [kos_pkg::STEP_W-1:0] step_r;
  logic ccw;

  always_comb begin
    // vectoring drives y to zero, rotation drives z to zero
    ccw   = vec_r ? y_r[kos_pkg::VEC_W-1] : !z_r[kos_pkg::ANG_W-1];
    if (ccw) begin
      x_nxt = x_r - (y_r >>> step_r);
      y_nxt = y_r + (x_r >>> step_r);
      z_nxt = z_r - kos_pkg::atan_deg(step_r);
    end else begin
      x_nxt = x_r + (y_r >>> step_r);
      y_nxt = y_r - (x_r >>> step_r);
      z_nxt = z_r + kos_pkg::atan_deg(step_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == kos_pkg::STEP_W'(kos_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r   <= req.x;
      y_r   <= req.y;
      z_r   <= req.z;
      vec_r <= req.vec_mode;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

/* sv/kos_divider.sv */
module kos_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [kos_pkg::DIVD_W-1:0]   dividend,
  input  logic [kos_pkg::DVSR_W-1:0]   divisor,
  output logic                         done,
  output logic [kos_pkg::DIVD_W-1:0]   quotient
);

  logic [kos_pkg::DVSR_W-1:0] rem_r, dvs_r;
  logic [kos_pkg::DIVD_W-1:0] quo_r;
  logic [kos_pkg::CNT_W-1:0]  cnt_r;
  logic busy_r, done_r;
  logic [kos_pkg::DVSR_W:0]   rem2;
  logic                       fits;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem2 = {rem_r, quo_r[kos_pkg::DIVD_W-1]};
    fits = rem2 >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == kos_pkg::CNT_W'(kos_pkg::DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? kos_pkg::DVSR_W'(rem2 - {1'b0, dvs_r})
                    : rem2[kos_pkg::DVSR_W-1:0];
      quo_r <= {quo_r[kos_pkg::DIVD_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* sv/kos_isqrt.sv */
module kos_isqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [kos_pkg::SQ_W-1:0] radicand,
  output logic                     done,
  output logic [kos_pkg::SQ_W-1:0] root
);

  logic [kos_pkg::SQ_W-1:0] n_r, r_r, b;
  logic [kos_pkg::SQ_W:0]   trial;
  logic [kos_pkg::STEP_W-1:0] k_r;
  logic busy_r, done_r;

  // bit-pair floor square root, one result bit a cycle
  always_comb begin
    b     = kos_pkg::SQ_W'(1) << {k_r, 1'b0};
    trial = {1'b0, r_r} + {1'b0, b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= kos_pkg::STEP_W'(kos_pkg::SQ_STEPS - 1);
      end else if (busy_r) begin
        k_r <= k_r - 1'b1;
        if (k_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r <= radicand;
      r_r <= '0;
    end else if (busy_r) begin
      if ({1'b0, n_r} >= trial) begin
        n_r <= n_r - trial[kos_pkg::SQ_W-1:0];
        r_r <= (r_r >> 1) + b;
      end else begin
        r_r <= r_r >> 1;
      end
    end
  end

  assign done = done_r;
  assign root = r_r;

endmodule

/* sv/kepler_orbit_solver.sv */
// Each Newton step run (at most iteration_limit) takes one CORDIC pass and one divide.
// Throughput: one item at a time; the next input is taken once the result is registered.
// Trig, products and divides go through one shared CORDIC, multiplier and divider, and
// the root through a sqrt unit; only the input e*e has a multiplier of its own.
// Reset (rst_n, synchronous, active low): idle, no result, iteration_limit 10, tolerance 328.
module kepler_orbit_solver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // mean_anom[24:0], eccentricity_in[40:25], semi_major[72:41]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // ecc_anom[25:0], true_anom[50:26], radius[83:51]
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  kos_pkg::state_t state_r, state_nxt;
  kos_pkg::phase_t phase_r;

  logic [3:0]  iter_limit_r;
  logic [15:0] tol_r;

  logic [24:0] m_r;
  logic [15:0] e_r;
  logic [31:0] a_r;
  logic [32:0] ome2_r;
  logic [3:0]  k_r;
  kos_pkg::ang_t ang_r;
  logic        flip_r;
  kos_pkg::mop_t s_r, c_r, es_r, ec_r, den_r;
  kos_pkg::est_t est_r, nxt_r;
  logic        fneg_r;
  logic [30:0] root_r;
  logic [24:0] v_r;
  logic [32:0] rad_r;
  kos_pkg::mop_t mul_a_r, mul_b_r, mul_a_nxt, mul_b_nxt;
  kos_pkg::prod_t prod_r;

  logic        out_valid_r;
  logic [25:0] o_ecc_r;
  logic [24:0] o_true_r;
  logic [32:0] o_rad_r;

  kos_pkg::cordic_req_t cord_req;
  logic          cord_done;
  kos_pkg::vec_t cord_x, cord_y;
  kos_pkg::ang_t cord_z;

  logic                        div_start, div_done;
  logic [kos_pkg::DIVD_W-1:0]  div_dividend, div_quot;
  logic [kos_pkg::DVSR_W-1:0]  div_divisor;
  logic                        sq_start, sq_done;
  logic [kos_pkg::SQ_W-1:0]    sq_root;

  // derived values
  kos_pkg::ang_t a1, a2, a3;
  logic          flip;
  kos_pkg::prod_t r16, r30, r38;
  kos_pkg::vec_t  f_val, f_abs;
  kos_pkg::mop_t  g_val, den_val;
  kos_pkg::prod_t q_s, diff;
  kos_pkg::est_t  nxt_val;
  logic signed [kos_pkg::EST_W:0] step_d;
  logic [kos_pkg::EST_W:0]        step_abs;
  kos_pkg::vec_t  tx, ty;
  kos_pkg::ang_t  vz;
  logic           can_out, last_step;

  always_comb begin
    // reduce to [-90,90] for the rotation pass
    if (ang_r < 0)                    a1 = ang_r + kos_pkg::DEG360;
    else if (ang_r >= kos_pkg::DEG360) a1 = ang_r - kos_pkg::DEG360;
    else                              a1 = ang_r;
    a2   = (a1 > kos_pkg::DEG180) ? a1 - kos_pkg::DEG360 : a1;
    flip = 1'b0;
    a3   = a2;
    if (a2 > kos_pkg::DEG90) begin
      a3   = a2 - kos_pkg::DEG180;
      flip = 1'b1;
    end else if (a2 < -kos_pkg::DEG90) begin
      a3   = a2 + kos_pkg::DEG180;
      flip = 1'b1;
    end

    r16 = kos_pkg::rnd_sh(prod_r, 16);
    r30 = kos_pkg::rnd_sh(prod_r, 30);
    r38 = kos_pkg::rnd_sh(prod_r, 38);

    f_val = kos_pkg::VEC_W'(est_r) - kos_pkg::VEC_W'(r38)
            - kos_pkg::VEC_W'({11'b0, m_r});
    f_abs = f_val[kos_pkg::VEC_W-1] ? -f_val : f_val;
    g_val = kos_pkg::ONE_Q30 - ec_r;
    if (g_val < 1) g_val = kos_pkg::mop_t'(1);

    q_s  = kos_pkg::prod_t'({2'b0, div_quot});
    if (fneg_r) q_s = -q_s;
    diff = kos_pkg::prod_t'(est_r) - q_s;
    if (diff < kos_pkg::prod_t'(kos_pkg::E_LOW))       nxt_val = kos_pkg::E_LOW;
    else if (diff > kos_pkg::prod_t'(kos_pkg::E_HIGH)) nxt_val = kos_pkg::E_HIGH;
    else                                               nxt_val = diff[kos_pkg::EST_W-1:0];

    step_d    = (kos_pkg::EST_W+1)'(nxt_r) - (kos_pkg::EST_W+1)'(est_r);
    step_abs  = step_d[kos_pkg::EST_W] ? unsigned'(-step_d) : unsigned'(step_d);
    last_step = ({1'b0, k_r} + 5'd1) == {1'b0, iter_limit_r};

    tx = kos_pkg::VEC_W'(c_r) - kos_pkg::VEC_W'({e_r, 14'b0});
    ty = r30[kos_pkg::VEC_W-1:0];

    if (cord_z < 0)                     vz = cord_z + kos_pkg::DEG360;
    else if (cord_z >= kos_pkg::DEG360) vz = cord_z - kos_pkg::DEG360;
    else                                vz = cord_z;

    den_val = kos_pkg::ONE_Q30 + r16[kos_pkg::MUL_W-1:0];
    if (den_val < 1) den_val = kos_pkg::mop_t'(1);

    can_out = !out_valid_r || out_tready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kos_pkg::ST_IDLE:     if (in_tvalid) state_nxt = kos_pkg::ST_CS_START;
      kos_pkg::ST_CS_START: state_nxt = kos_pkg::ST_CS_WAIT;
      kos_pkg::ST_CS_WAIT:  if (cord_done) state_nxt = kos_pkg::ST_SC;
      kos_pkg::ST_SC:       state_nxt = kos_pkg::ST_SC_W;
      kos_pkg::ST_SC_W: begin
        unique case (phase_r)
          kos_pkg::PH_TRUE: state_nxt = kos_pkg::ST_Y2;
          kos_pkg::PH_RAD:  state_nxt = kos_pkg::ST_RD2;
          default:          state_nxt = kos_pkg::ST_EC;
        endcase
      end
      kos_pkg::ST_EC:       state_nxt = kos_pkg::ST_EC_W;
      kos_pkg::ST_EC_W:     state_nxt = kos_pkg::ST_EC2;
      kos_pkg::ST_EC2:      state_nxt = kos_pkg::ST_EC2_W;
      kos_pkg::ST_EC2_W:
        state_nxt = (phase_r == kos_pkg::PH_INIT) ? kos_pkg::ST_T2 : kos_pkg::ST_F2;
      kos_pkg::ST_T2:       state_nxt = kos_pkg::ST_T2_W;
      kos_pkg::ST_T2_W:     state_nxt = kos_pkg::ST_EST;
      kos_pkg::ST_EST:
        state_nxt = (iter_limit_r == '0) ? kos_pkg::ST_SQ : kos_pkg::ST_CS_START;
      kos_pkg::ST_F2:       state_nxt = kos_pkg::ST_DIV_W;
      kos_pkg::ST_DIV_W:    if (div_done) state_nxt = kos_pkg::ST_CHK;
      kos_pkg::ST_CHK: begin
        if (step_abs < {11'b0, tol_r} || last_step) state_nxt = kos_pkg::ST_SQ;
        else                                        state_nxt = kos_pkg::ST_CS_START;
      end
      kos_pkg::ST_SQ:       state_nxt = kos_pkg::ST_SQ_W;
      kos_pkg::ST_SQ_W:     if (sq_done) state_nxt = kos_pkg::ST_CS_START;
      kos_pkg::ST_Y2:
        state_nxt = (tx == '0 && ty == '0) ? kos_pkg::ST_CS_START : kos_pkg::ST_AT_W;
      kos_pkg::ST_AT_W:     if (cord_done) state_nxt = kos_pkg::ST_CS_START;
      kos_pkg::ST_RD2:      state_nxt = kos_pkg::ST_RD2_W;
      kos_pkg::ST_RD2_W:    state_nxt = kos_pkg::ST_RD3;
      kos_pkg::ST_RD3:      state_nxt = kos_pkg::ST_RD_DIV;
      kos_pkg::ST_RD_DIV:   if (div_done) state_nxt = kos_pkg::ST_DONE;
      kos_pkg::ST_DONE:     if (can_out) state_nxt = kos_pkg::ST_IDLE;
      default:              state_nxt = kos_pkg::ST_IDLE;
    endcase
  end

  // unit controls and multiplier operands
  always_comb begin
    cord_req     = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    sq_start     = 1'b0;
    mul_a_nxt    = mul_a_r;
    mul_b_nxt    = mul_b_r;
    unique case (state_r)
      kos_pkg::ST_CS_START: begin
        cord_req.start = 1'b1;
        cord_req.x     = kos_pkg::CORDIC_GAIN;
        cord_req.z     = a3;
      end
      kos_pkg::ST_SC: begin
        unique case (phase_r)
          kos_pkg::PH_TRUE: begin
            mul_a_nxt = kos_pkg::mop_t'({3'b0, root_r});
            mul_b_nxt = s_r;
          end
          kos_pkg::PH_RAD: begin
            mul_a_nxt = kos_pkg::mop_t'({18'b0, e_r});
            mul_b_nxt = c_r;
          end
          default: begin
            mul_a_nxt = kos_pkg::mop_t'({18'b0, e_r});
            mul_b_nxt = s_r;
          end
        endcase
      end
      kos_pkg::ST_EC: begin
        mul_a_nxt = kos_pkg::mop_t'({18'b0, e_r});
        mul_b_nxt = c_r;
      end
      kos_pkg::ST_EC2: begin
        mul_a_nxt = es_r;
        mul_b_nxt = (phase_r == kos_pkg::PH_INIT)
                    ? kos_pkg::ONE_Q30 + r16[kos_pkg::MUL_W-1:0] : kos_pkg::RAD_TO_DEG;
      end
      kos_pkg::ST_T2: begin
        mul_a_nxt = r30[kos_pkg::MUL_W-1:0];
        mul_b_nxt = kos_pkg::RAD_TO_DEG;
      end
      kos_pkg::ST_F2: begin
        div_start    = 1'b1;
        div_dividend = kos_pkg::DIVD_W'(unsigned'(f_abs)) << 30;
        div_divisor  = unsigned'(g_val);
      end
      kos_pkg::ST_SQ:   sq_start = 1'b1;
      kos_pkg::ST_Y2: begin
        cord_req.start    = !(tx == '0 && ty == '0);
        cord_req.vec_mode = 1'b1;
        cord_req.x        = tx[kos_pkg::VEC_W-1] ? -tx : tx;
        cord_req.y        = tx[kos_pkg::VEC_W-1] ? -ty : ty;
        cord_req.z        = tx[kos_pkg::VEC_W-1] ? kos_pkg::DEG180 : '0;
      end
      kos_pkg::ST_RD2: begin
        mul_a_nxt = kos_pkg::mop_t'({2'b0, a_r});
        mul_b_nxt = kos_pkg::mop_t'({1'b0, ome2_r});
      end
      kos_pkg::ST_RD3: begin
        div_start    = 1'b1;
        div_dividend = prod_r[kos_pkg::DIVD_W-1:0]
                       + (kos_pkg::DIVD_W'(unsigned'(den_r)) << 1);
        div_divisor  = unsigned'(den_r) << 2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kos_pkg::ST_IDLE;
      iter_limit_r <= kos_pkg::ITER_RESET;
      tol_r        <= kos_pkg::TOL_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          kos_pkg::CFG_ITER_LIMIT: iter_limit_r <= cfg_wdata[3:0];
          kos_pkg::CFG_TOLERANCE:  tol_r        <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == kos_pkg::ST_DONE && can_out) out_valid_r <= 1'b1;
      else if (out_tready)                        out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    mul_a_r <= mul_a_nxt;
    mul_b_r <= mul_b_nxt;
    prod_r  <= mul_a_r * mul_b_r;
    unique case (state_r)
      kos_pkg::ST_IDLE: if (in_tvalid) begin
        m_r     <= in_tdata[24:0];
        e_r     <= in_tdata[40:25];
        a_r     <= in_tdata[72:41];
        ome2_r  <= 33'h1_0000_0000
                   - {1'b0, 32'(in_tdata[40:25]) * 32'(in_tdata[40:25])};
        ang_r   <= kos_pkg::ang_t'({2'b0, in_tdata[24:0]});
        phase_r <= kos_pkg::PH_INIT;
        k_r     <= '0;
      end
      kos_pkg::ST_CS_START: flip_r <= flip;
      kos_pkg::ST_CS_WAIT: if (cord_done) begin
        s_r <= flip_r ? -cord_y[kos_pkg::MUL_W-1:0] : cord_y[kos_pkg::MUL_W-1:0];
        c_r <= flip_r ? -cord_x[kos_pkg::MUL_W-1:0] : cord_x[kos_pkg::MUL_W-1:0];
      end
      kos_pkg::ST_EC:  es_r <= r16[kos_pkg::MUL_W-1:0];
      kos_pkg::ST_EC2: ec_r <= r16[kos_pkg::MUL_W-1:0];
      kos_pkg::ST_EST: begin
        // start estimate, saturated
        if (kos_pkg::prod_t'({2'b0, m_r}) + r38 < kos_pkg::prod_t'(kos_pkg::E_LOW)) begin
          est_r <= kos_pkg::E_LOW;
          nxt_r <= kos_pkg::E_LOW;
          ang_r <= kos_pkg::ANG_W'(kos_pkg::E_LOW);
        end else if (kos_pkg::prod_t'({2'b0, m_r}) + r38
                     > kos_pkg::prod_t'(kos_pkg::E_HIGH)) begin
          est_r <= kos_pkg::E_HIGH;
          nxt_r <= kos_pkg::E_HIGH;
          ang_r <= kos_pkg::ANG_W'(kos_pkg::E_HIGH);
        end else begin
          est_r <= kos_pkg::EST_W'(kos_pkg::prod_t'({2'b0, m_r}) + r38);
          nxt_r <= kos_pkg::EST_W'(kos_pkg::prod_t'({2'b0, m_r}) + r38);
          ang_r <= kos_pkg::ANG_W'(kos_pkg::prod_t'({2'b0, m_r}) + r38);
        end
        phase_r <= kos_pkg::PH_NEWTON;
      end
      kos_pkg::ST_F2:    fneg_r <= f_val[kos_pkg::VEC_W-1];
      kos_pkg::ST_DIV_W: if (div_done) nxt_r <= nxt_val;
      kos_pkg::ST_CHK: begin
        est_r <= nxt_r;
        ang_r <= kos_pkg::ANG_W'(nxt_r);
        k_r   <= k_r + 1'b1;
      end
      kos_pkg::ST_SQ_W: if (sq_done) begin
        root_r  <= sq_root[30:0];
        ang_r   <= kos_pkg::ANG_W'(nxt_r);
        phase_r <= kos_pkg::PH_TRUE;
      end
      kos_pkg::ST_Y2: begin
        // zero vector: true anomaly is zero
        v_r     <= '0;
        ang_r   <= '0;
        phase_r <= kos_pkg::PH_RAD;
      end
      kos_pkg::ST_AT_W: if (cord_done) begin
        v_r   <= vz[24:0];
        ang_r <= vz;
      end
      kos_pkg::ST_RD2: den_r <= den_val;
      kos_pkg::ST_RD_DIV: if (div_done) begin
        rad_r <= (div_quot > kos_pkg::DIVD_W'(kos_pkg::RADIUS_MAX))
                 ? kos_pkg::RADIUS_MAX : div_quot[32:0];
      end
      kos_pkg::ST_DONE: if (can_out) begin
        o_ecc_r  <= unsigned'(nxt_r);
        o_true_r <= v_r;
        o_rad_r  <= rad_r;
      end
      default: ;
    endcase
  end

  kos_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cord_req),
    .done  (cord_done),
    .x_out (cord_x),
    .y_out (cord_y),
    .z_out (cord_z)
  );

  kos_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  kos_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand ({ome2_r, 28'b0}),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign in_tready  = (state_r == kos_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, o_rad_r, o_true_r, o_ecc_r};

  // one item in flight: a request is followed by a busy period
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request taken while busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[50:26] < 25'd23592960))
    else $error("true anomaly out of [0,360)");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[25:0]) >= kos_pkg::E_LOW
                    && $signed(out_tdata[25:0]) <= kos_pkg::E_HIGH))
    else $error("eccentric anomaly outside saturation range");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kos_pkg::ST_IDLE) |-> !cord_done && !div_done && !sq_done)
    else $error("unit finished while sequencer idle");

endmodule

/* tb/sv/kepler_checker.sv */
`timescale 1ns / 1ps

module kepler_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          orbits_pending
);

  typedef struct {
    logic signed [25:0] ecc_anom;
    logic [24:0]        true_anom;
    logic [32:0]        radius;
  } orbit_t;

  localparam longint Q30       = 64'sd1 <<< 30;
  localparam longint FULL_TURN = 64'sd23592960;
  localparam longint HALF_TURN = 64'sd11796480;
  localparam longint QTR_TURN  = 64'sd5898240;
  localparam longint RAD2DEG   = 64'sd961263669;
  localparam longint GAIN      = 64'sd652032874;
  localparam longint ATAN_TAB [19] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14
  };

  logic [3:0]  iter_limit;
  logic [15:0] step_tol;
  orbit_t      orbit_q[$];
  int          mismatches;

  function automatic longint rnd(input longint x, input int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_e(input longint x);
    if (x < longint'(kos_pkg::E_LOW)) return longint'(kos_pkg::E_LOW);
    if (x > longint'(kos_pkg::E_HIGH)) return longint'(kos_pkg::E_HIGH);
    return x;
  endfunction

  function automatic longint norm_deg(input longint a);
    longint r;
    r = a % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    return r;
  endfunction

  task automatic sincos_deg(input longint ang, output longint s, output longint c);
    longint a, x, y, nx;
    bit flip;
    a = norm_deg(ang);
    flip = 0;
    x = GAIN;
    y = 0;
    if (a > HALF_TURN) a -= FULL_TURN;
    if (a > QTR_TURN) begin
      a -= HALF_TURN;
      flip = 1;
    end else if (a < -QTR_TURN) begin
      a += HALF_TURN;
      flip = 1;
    end
    for (int i = 0; i < 19; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        a -= ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        a += ATAN_TAB[i];
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic longint vector_angle(input longint yi, input longint xi);
    longint x, y, z, nx;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    for (int i = 0; i < 19; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ATAN_TAB[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ATAN_TAB[i];
      end
      x = nx;
    end
    return norm_deg(z);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] r, b, m;
    r = 0;
    m = n;
    b = 64'd1 << 62;
    while (b > m) b >>= 2;
    while (b != 0) begin
      if (m >= r + b) begin
        m -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic solve_orbit(input logic [79:0] req, output orbit_t res);
    longint m, e, s, c, es, ec, t, est, nxt, f, g, q, d, x, y, v, den;
    logic [63:0] a, ome2, root, num, r;
    m = longint'(req[24:0]);
    e = longint'(req[40:25]);
    a = 64'(req[72:41]);
    sincos_deg(m, s, c);
    es  = rnd(e * s, 16);
    ec  = rnd(e * c, 16);
    t   = rnd(es * (Q30 + ec), 30);
    est = clamp_e(m + rnd(t * RAD2DEG, 38));
    nxt = est;
    for (int k = 0; k < iter_limit; k++) begin
      sincos_deg(est, s, c);
      es = rnd(e * s, 16);
      ec = rnd(e * c, 16);
      f  = est - rnd(es * RAD2DEG, 38) - m;
      g  = Q30 - ec;
      if (g < 1) g = 1;
      q   = (f * Q30) / g;
      nxt = clamp_e(est - q);
      d   = nxt - est;
      if (d < 0) d = -d;
      if (d < longint'(step_tol)) break;
      est = nxt;
    end
    ome2 = (64'd1 << 32) - 64'(req[40:25]) * 64'(req[40:25]);
    root = floor_sqrt(ome2 << 28);
    sincos_deg(nxt, s, c);
    x = c - (e <<< 14);
    y = rnd(longint'(root) * s, 30);
    v = vector_angle(y, x);
    sincos_deg(v, s, c);
    den = Q30 + rnd(e * c, 16);
    if (den < 1) den = 1;
    num = a * ome2;
    r   = (num + 2 * 64'(den)) / (4 * 64'(den));
    if (r > 64'(kos_pkg::RADIUS_MAX)) r = 64'(kos_pkg::RADIUS_MAX);
    res.ecc_anom  = nxt[25:0];
    res.true_anom = v[24:0];
    res.radius    = r[32:0];
  endtask

  always @(posedge clk) begin
    orbit_t exp_o, got;
    if (!rst_n) begin
      iter_limit     <= kos_pkg::ITER_RESET;
      step_tol       <= kos_pkg::TOL_RESET;
      orbit_q.delete();
      fail_count     <= 0;
      mismatches     = 0;
      orbits_pending <= 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == kos_pkg::CFG_ITER_LIMIT) iter_limit <= cfg_wdata[3:0];
        else if (cfg_index == kos_pkg::CFG_TOLERANCE) step_tol <= cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        got.ecc_anom  = out_tdata[25:0];
        got.true_anom = out_tdata[50:26];
        got.radius    = out_tdata[83:51];
        if (orbit_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          exp_o = orbit_q.pop_front();
          if (got.ecc_anom !== exp_o.ecc_anom || got.true_anom !== exp_o.true_anom ||
              got.radius !== exp_o.radius) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch E %0d/%0d v %0d/%0d r %0d/%0d (exp/got)",
                       exp_o.ecc_anom, got.ecc_anom, exp_o.true_anom, got.true_anom,
                       exp_o.radius, got.radius);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        solve_orbit(in_tdata, exp_o);
        orbit_q.push_back(exp_o);
      end
      fail_count     <= mismatches;
      orbits_pending <= orbit_q.size();
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 8_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // mean_anom[24:0], eccentricity_in[40:25], semi_major[72:41]
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;  // ecc_anom[25:0], true_anom[50:26], radius[83:51]
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          orbits_pending;
  int          hold_off;
  int          burst_left;

  kepler_orbit_solver u_dut (.*);

  kepler_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL kepler_orbit_solver");
        $finish;
      end
    end
  end

  // receiver: random stalls, with some draws forced ready, one long hold-off on request
  initial begin
    int mode;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off--;
        out_tready <= 1'b0;
      end else begin
        mode = ($urandom_range(0, 199) < 20) ? 1 : 0;
        out_tready <= mode ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic write_regs(input logic [3:0] limit, input logic [15:0] tol);
    cfg_wr_en <= 1'b1;
    cfg_index <= kos_pkg::CFG_ITER_LIMIT;
    cfg_wdata <= {12'd0, limit};
    @(posedge clk);
    cfg_index <= kos_pkg::CFG_TOLERANCE;
    cfg_wdata <= tol;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_orbit(input logic [24:0] m, input logic [15:0] e, input logic [31:0] a);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, a, e, m};
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      burst_left = $urandom_range(0, 6);
      repeat ($urandom_range(0, 12)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (orbits_pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic random_orbits(input int n);
    logic [24:0] m;
    logic [15:0] e;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       m = 25'($urandom);
        1:       m = 25'($urandom_range(0, 40)) * 25'd589824;
        default: m = 25'($urandom_range(0, 23592959));
      endcase
      case ($urandom_range(0, 5))
        0:       e = 16'($urandom_range(60000, 65535));
        1:       e = 16'($urandom_range(0, 2000));
        default: e = 16'($urandom);
      endcase
      send_orbit(m, e, $urandom);
    end
  endtask

  initial begin
    rst_n      = 0;
    in_tvalid  = 0;
    in_tdata   = '0;
    cfg_wr_en  = 0;
    cfg_index  = kos_pkg::CFG_ITER_LIMIT;
    cfg_wdata  = '0;
    hold_off   = 0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values first
    send_orbit(25'd0, 16'd0, 32'd0);
    send_orbit(25'd23592959, 16'd65535, 32'hFFFF_FFFF);
    send_orbit(25'd11796480, 16'd65535, 32'h0100_0000);
    send_orbit(25'd5898240, 16'd32768, 32'hFFFF_FFFF);
    send_orbit(25'h1FF_FFFF, 16'd1, 32'd1);
    send_orbit(25'd65536, 16'd65535, 32'h8000_0000);
    send_orbit(25'd23527424, 16'd65000, 32'hFFFF_FFFF);
    send_orbit(25'd1, 16'd65535, 32'd0);
    drain();

    write_regs(4'd0, 16'd65535);
    send_orbit(25'd3000000, 16'd40000, 32'h0200_0000);
    send_orbit(25'd23592959, 16'd65535, 32'hFFFF_FFFF);
    send_orbit(25'h1FF_FFFF, 16'd12345, 32'h1234_5678);
    drain();

    write_regs(4'd15, 16'd0);
    send_orbit(25'd0, 16'd65535, 32'hFFFF_FFFF);
    send_orbit(25'd11796479, 16'd65535, 32'h0100_0000);
    send_orbit(25'd200, 16'd65535, 32'd5);
    send_orbit(25'd17000000, 16'd50000, 32'hFFFF_FFFF);
    send_orbit(25'h155_5555, 16'haaaa, 32'h5555_5555);
    drain();

    write_regs(4'd1, 16'd65535);
    random_orbits(60);
    drain();

    // long enough for one result to wait in the output register and the next in the core
    write_regs(4'd15, 16'd0);
    hold_off = 8000;
    random_orbits(80);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_regs(4'($urandom_range(0, 15)), 16'($urandom_range(0, 2000)));
      random_orbits(100);
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS kepler_orbit_solver");
    end else begin
      $display("FAIL kepler_orbit_solver");
    end
    $finish;
  end

endmodule

/* kepler_orbit_solver.f */
sv/kos_pkg.sv
sv/kos_cordic.sv
sv/kos_divider.sv
sv/kos_isqrt.sv
sv/kepler_orbit_solver.sv
tb/sv/kepler_checker.sv
tb/sv/tb.sv
